/* hw/rtl/psgd_pkg.sv */
package psgd_pkg;

    typedef enum logic [2:0] {
        K_WRITE  = 3'd0,
        K_KEYON  = 3'd1,
        K_KEYOFF = 3'd2,
        K_ENVSEL = 3'd3,
        K_DUE    = 3'd4,
        K_WAIT   = 3'd5,
        K_END    = 3'd6,
        K_ERROR  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        F_BYTE  = 2'd0,
        F_TICK  = 2'd1,
        F_LEVEL = 2'd2,
        F_START = 2'd3
    } func_t;

    typedef enum logic [5:0] {
        PH_HEAD0 = 6'b000001,
        PH_HEAD1 = 6'b000010,
        PH_CMD   = 6'b000100,
        PH_OPND1 = 6'b001000,
        PH_OPND2 = 6'b010000,
        PH_SKIP  = 6'b100000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
        logic [3:0] env_index;
    } res_t;

    // work handed from the front to the back: up to three results
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
        res_t       r2;
    } job_t;

    // body command codes, high nibble of the command byte
    localparam logic [3:0] OP_TONE_KEY  = 4'h0;
    localparam logic [3:0] OP_KEY_OFF   = 4'h1;
    localparam logic [3:0] OP_NOISE_A   = 4'h2;
    localparam logic [3:0] OP_NOISE_B   = 4'h3;
    localparam logic [3:0] OP_CYCLE     = 4'h4;
    localparam logic [3:0] OP_MIXER     = 4'h7;
    localparam logic [3:0] OP_AMP       = 4'h8;
    localparam logic [3:0] OP_PATTERN   = 4'h9;
    localparam logic [3:0] OP_ENV_SEL   = 4'hc;
    localparam logic [3:0] OP_PAT_CYCLE = 4'hd;
    localparam logic [3:0] OP_TONE      = 4'he;

    // sound generator register numbers
    localparam logic [3:0] REG_NOISE      = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_VOL_BASE   = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

    localparam int QDEPTH = 4;
    localparam logic [7:0] END_MARK = 8'd255;
    localparam logic [4:0] NOISE_MASK = 5'h1f;
    localparam logic [7:0] HW_ENV_VOL = 8'h10;
    localparam int LEVEL_OFFSET = 30;

    function automatic res_t mk(input kind_t k, input logic [3:0] a,
                                input logic [7:0] v, input logic [3:0] e);
        res_t r;
        r.kind = k;
        r.reg_addr = a;
        r.reg_value = v;
        r.env_index = e;
        return r;
    endfunction

endpackage

/* hw/rtl/psgd_front.sv */
module psgd_front #(
    parameter int SPEED_UNIT = 4,
    parameter int VOICES = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        func,
    input  logic [1:0]        channel,
    input  logic [7:0]        data,
    input  logic              muted,
    input  logic [3:0]        master_volume,
    output logic              job_valid,
    output psgd_pkg::job_t    job
);

    localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;

    psgd_pkg::phase_t phase_reg [VOICES];
    logic [2:0]  body_reg [VOICES];
    logic [7:0]  pend_reg [VOICES];
    logic [7:0]  hhigh_reg [VOICES];
    logic [15:0] wait_reg [VOICES];
    logic [3:0]  amp_reg [VOICES];
    logic        hwon_reg [VOICES];
    logic        act_reg [VOICES];
    logic [3:0]  pat_reg;

    psgd_pkg::phase_t ph_next;
    logic [2:0]  body_next;
    logic [7:0]  pend_next;
    logic [7:0]  hhigh_next;
    logic [15:0] wait_next;
    logic [3:0]  amp_next;
    logic        hwon_next;
    logic        act_next;
    logic [3:0]  pat_next;

    logic [CW-1:0] ch;
    logic          ch_ok;
    logic [3:0]    nib;
    logic [2:0]    bl;
    logic [1:0]    need;
    logic [17:0]   wsum;
    logic [6:0]    lvl;
    logic [3:0]    vol_addr;
    logic [3:0]    tone_hi;
    logic [3:0]    tone_lo;
    psgd_pkg::res_t r0, r1, r2;
    logic [1:0]    cnt;

    assign ch = channel[CW-1:0];
    assign ch_ok = (32'(channel) < VOICES);
    assign nib = data[7:4];
    assign vol_addr = psgd_pkg::REG_VOL_BASE + 4'(channel);
    assign tone_hi = 4'd1 + {1'b0, channel, 1'b0};
    assign tone_lo = {1'b0, channel, 1'b0};

    always_comb begin
        ph_next = phase_reg[ch];
        body_next = body_reg[ch];
        pend_next = pend_reg[ch];
        hhigh_next = hhigh_reg[ch];
        wait_next = wait_reg[ch];
        amp_next = amp_reg[ch];
        hwon_next = hwon_reg[ch];
        act_next = act_reg[ch];
        pat_next = pat_reg;
        r0 = '0;
        r1 = '0;
        r2 = '0;
        cnt = 2'd0;
        bl = (body_reg[ch] != 3'd0) ? body_reg[ch] - 3'd1 : 3'd0;
        need = 2'd0;
        wsum = 18'({2'b0, wait_reg[ch]}) +
               18'(SPEED_UNIT) * 18'({hhigh_reg[ch][4:0], data});
        lvl = 7'({3'b0, nib}) + 7'({3'b0, amp_reg[ch]}) + 7'({3'b0, master_volume});
        if (func == psgd_pkg::F_START) begin
            act_next = 1'b1;
            ph_next = psgd_pkg::PH_HEAD0;
            body_next = 3'd0;
            wait_next = 16'd0;
        end else if (act_reg[ch]) begin
            unique case (func)
                psgd_pkg::F_TICK: begin
                    cnt = 2'd1;
                    if (16'(data) < wait_reg[ch]) begin
                        wait_next = wait_reg[ch] - 16'(data);
                        r0 = psgd_pkg::mk(psgd_pkg::K_WAIT, 4'd0, 8'd0, 4'd0);
                    end else begin
                        wait_next = 16'd0;
                        r0 = psgd_pkg::mk(psgd_pkg::K_DUE, 4'd0, 8'd0, 4'd0);
                    end
                end
                psgd_pkg::F_LEVEL: begin
                    if (!muted && !hwon_reg[ch]) begin
                        cnt = 2'd1;
                        r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, vol_addr,
                            (lvl > 7'(psgd_pkg::LEVEL_OFFSET)) ?
                            8'(lvl - 7'(psgd_pkg::LEVEL_OFFSET)) : 8'd0, 4'd0);
                    end
                end
                psgd_pkg::F_BYTE: begin
                    unique case (phase_reg[ch])
                        psgd_pkg::PH_HEAD0: begin
                            if (data == psgd_pkg::END_MARK) begin
                                act_next = 1'b0;
                                cnt = 2'd1;
                                r0 = psgd_pkg::mk(psgd_pkg::K_END, 4'd0, 8'd0, 4'd0);
                            end else begin
                                hhigh_next = data;
                                ph_next = psgd_pkg::PH_HEAD1;
                            end
                        end
                        psgd_pkg::PH_HEAD1: begin
                            wait_next = (wsum > 18'hffff) ? 16'hffff : wsum[15:0];
                            body_next = hhigh_reg[ch][7:5];
                            if (hhigh_reg[ch][7:5] == 3'd0) ph_next = psgd_pkg::PH_HEAD0;
                            else ph_next = muted ? psgd_pkg::PH_SKIP : psgd_pkg::PH_CMD;
                        end
                        psgd_pkg::PH_SKIP: begin
                            body_next = bl;
                            if (bl == 3'd0) ph_next = psgd_pkg::PH_HEAD0;
                        end
                        psgd_pkg::PH_CMD: begin
                            body_next = bl;
                            case (nib) inside
                                psgd_pkg::OP_TONE_KEY, psgd_pkg::OP_TONE,
                                psgd_pkg::OP_MIXER:     need = 2'd1;
                                psgd_pkg::OP_CYCLE,
                                psgd_pkg::OP_PAT_CYCLE: need = 2'd2;
                                default:                need = 2'd0;
                            endcase
                            if (3'(need) > bl) begin
                                act_next = 1'b0;
                                ph_next = psgd_pkg::PH_HEAD0;
                                body_next = 3'd0;
                                cnt = 2'd1;
                                r0 = psgd_pkg::mk(psgd_pkg::K_ERROR, 4'd0, 8'd0, 4'd0);
                            end else begin
                                pend_next = data;
                                ph_next = (bl != 3'd0) ? psgd_pkg::PH_CMD
                                                       : psgd_pkg::PH_HEAD0;
                                case (nib) inside
                                    psgd_pkg::OP_TONE_KEY: begin
                                        r0 = psgd_pkg::mk(psgd_pkg::K_KEYON, 4'd0, 8'd0, 4'd0);
                                        r1 = psgd_pkg::mk(psgd_pkg::K_WRITE,
                                                          psgd_pkg::REG_ENV_SHAPE,
                                                          {4'd0, pat_reg}, 4'd0);
                                        r2 = psgd_pkg::mk(psgd_pkg::K_WRITE, vol_addr,
                                                          psgd_pkg::HW_ENV_VOL, 4'd0);
                                        cnt = hwon_reg[ch] ? 2'd3 : 2'd1;
                                        ph_next = psgd_pkg::PH_OPND1;
                                    end
                                    psgd_pkg::OP_TONE, psgd_pkg::OP_MIXER,
                                    psgd_pkg::OP_CYCLE: ph_next = psgd_pkg::PH_OPND1;
                                    psgd_pkg::OP_KEY_OFF: begin
                                        r0 = psgd_pkg::mk(psgd_pkg::K_KEYOFF, 4'd0, 8'd0, 4'd0);
                                        r1 = psgd_pkg::mk(psgd_pkg::K_WRITE, vol_addr,
                                                          8'd0, 4'd0);
                                        cnt = hwon_reg[ch] ? 2'd2 : 2'd1;
                                    end
                                    psgd_pkg::OP_NOISE_A, psgd_pkg::OP_NOISE_B: begin
                                        cnt = 2'd1;
                                        r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, psgd_pkg::REG_NOISE,
                                            {3'd0, data[4:0] & psgd_pkg::NOISE_MASK}, 4'd0);
                                    end
                                    psgd_pkg::OP_AMP: begin
                                        amp_next = data[3:0];
                                        hwon_next = 1'b0;
                                    end
                                    psgd_pkg::OP_ENV_SEL: begin
                                        hwon_next = 1'b0;
                                        cnt = 2'd1;
                                        r0 = psgd_pkg::mk(psgd_pkg::K_ENVSEL, 4'd0, 8'd0,
                                                          data[3:0]);
                                    end
                                    psgd_pkg::OP_PATTERN, psgd_pkg::OP_PAT_CYCLE: begin
                                        pat_next = data[3:0];
                                        hwon_next = 1'b1;
                                        if (nib == psgd_pkg::OP_PAT_CYCLE)
                                            ph_next = psgd_pkg::PH_OPND1;
                                    end
                                    default: begin
                                        act_next = 1'b0;
                                        ph_next = psgd_pkg::PH_HEAD0;
                                        body_next = 3'd0;
                                        cnt = 2'd1;
                                        r0 = psgd_pkg::mk(psgd_pkg::K_ERROR, 4'd0, 8'd0, 4'd0);
                                    end
                                endcase
                            end
                        end
                        psgd_pkg::PH_OPND1: begin
                            body_next = bl;
                            ph_next = (bl != 3'd0) ? psgd_pkg::PH_CMD : psgd_pkg::PH_HEAD0;
                            if (pend_reg[ch][7:4] == psgd_pkg::OP_TONE_KEY ||
                                pend_reg[ch][7:4] == psgd_pkg::OP_TONE) begin
                                cnt = 2'd2;
                                r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, tone_hi,
                                                  {4'd0, pend_reg[ch][3:0]}, 4'd0);
                                r1 = psgd_pkg::mk(psgd_pkg::K_WRITE, tone_lo, data, 4'd0);
                            end else if (pend_reg[ch][7:4] == psgd_pkg::OP_MIXER) begin
                                cnt = 2'd1;
                                r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, psgd_pkg::REG_MIXER,
                                                  data, 4'd0);
                            end else begin
                                cnt = 2'd1;
                                r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, psgd_pkg::REG_ENV_COARSE,
                                                  data, 4'd0);
                                ph_next = psgd_pkg::PH_OPND2;
                            end
                        end
                        psgd_pkg::PH_OPND2: begin
                            body_next = bl;
                            ph_next = (bl != 3'd0) ? psgd_pkg::PH_CMD : psgd_pkg::PH_HEAD0;
                            cnt = 2'd1;
                            r0 = psgd_pkg::mk(psgd_pkg::K_WRITE, psgd_pkg::REG_ENV_FINE,
                                              data, 4'd0);
                        end
                        default: ph_next = psgd_pkg::PH_HEAD0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                phase_reg[i] <= psgd_pkg::PH_HEAD0;
                body_reg[i] <= 3'd0;
                pend_reg[i] <= 8'd0;
                hhigh_reg[i] <= 8'd0;
                wait_reg[i] <= 16'd0;
                amp_reg[i] <= 4'd0;
                hwon_reg[i] <= 1'b0;
                act_reg[i] <= 1'b0;
            end
            pat_reg <= 4'd0;
        end else if (in_valid && ch_ok) begin
            phase_reg[ch] <= ph_next;
            body_reg[ch] <= body_next;
            pend_reg[ch] <= pend_next;
            hhigh_reg[ch] <= hhigh_next;
            wait_reg[ch] <= wait_next;
            amp_reg[ch] <= amp_next;
            hwon_reg[ch] <= hwon_next;
            act_reg[ch] <= act_next;
            pat_reg <= pat_next;
        end
    end

    assign job_valid = in_valid && ch_ok && (cnt != 2'd0);
    assign job.count = cnt;
    assign job.r0 = r0;
    assign job.r1 = r1;
    assign job.r2 = r2;

endmodule

/* hw/rtl/psgd_back.sv */
module psgd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    input  psgd_pkg::job_t    job,
    output logic              job_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [2:0]        m_tuser,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);

    localparam int AW = $clog2(psgd_pkg::QDEPTH);

    psgd_pkg::job_t q_reg [psgd_pkg::QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic [1:0]    sub_reg;
    logic          push, pop;
    psgd_pkg::job_t head;
    psgd_pkg::res_t cur;

    assign head = q_reg[rp_reg];
    assign job_ready = (cnt_reg < (AW+1)'(psgd_pkg::QDEPTH));
    assign push = job_valid && job_ready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast = (2'(sub_reg + 2'd1) == head.count);
    assign pop = m_tvalid && m_tready && m_tlast;

    always_comb begin
        case (sub_reg)
            2'd0:    cur = head.r0;
            2'd1:    cur = head.r1;
            default: cur = head.r2;
        endcase
    end

    assign m_tuser = cur.kind;
    assign m_tdata = {cur.env_index, cur.reg_value, cur.reg_addr};

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            sub_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
            if (m_tvalid && m_tready) sub_reg <= m_tlast ? 2'd0 : sub_reg + 2'd1;
        end
    end

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(psgd_pkg::QDEPTH)) else $error("queue overflow");
    a_head_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> head.count != 2'd0) else $error("empty job queued");
    a_sub: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> sub_reg < head.count) else $error("sub index past job");

endmodule

/* hw/rtl/psg_music_stream_decoder_unit.sv */
// channel | dir | fields (low bit up)
// s_axis  | in  | tuser: func; tdata: channel[1:0] data[9:2] muted[10]
// m_axis  | out | tuser: kind; tdata: reg_addr[3:0] reg_value[11:4] env_index[15:12]
// m_axis  | out | tlast: last
// cfg     | in  | cfg_data: master_volume
// one input item per cycle; results one per cycle if m_tready, up to three per item
// a four-entry job queue between decode and output sets the stall slack
// s_tready drops only while that queue is full
// synchronous active-low reset returns all voices inactive, master volume 15
module psg_music_stream_decoder_unit #(
    parameter int SPEED_UNIT = 4,
    parameter int VOICES = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // func
    input  logic [15:0] s_tdata,   // channel, data, muted
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // kind
    output logic [15:0] m_tdata,   // reg_addr, reg_value, env_index
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [3:0] mvol_reg;
    logic job_valid, job_ready;
    psgd_pkg::job_t job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) mvol_reg <= 4'd15;
        else if (cfg_valid) mvol_reg <= cfg_data;
    end

    assign s_tready = job_ready;

    psgd_front #(.SPEED_UNIT(SPEED_UNIT), .VOICES(VOICES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && s_tready),
        .func(s_tuser), .channel(s_tdata[1:0]), .data(s_tdata[9:2]),
        .muted(s_tdata[10]), .master_volume(mvol_reg),
        .job_valid(job_valid), .job(job)
    );

    psgd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job(job), .job_ready(job_ready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule

/* tb/psgd_checker.sv */
`timescale 1ns / 1ps

module psgd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [2:0]  m_tuser,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        psgd_pkg::res_t r;
        logic last;
    } decoded_t;

    decoded_t   expected_q[$];

    logic [3:0]  master_vol;
    psgd_pkg::phase_t phase [3];
    logic [2:0]  body_left [3];
    logic [7:0]  cmd_byte [3];
    logic [7:0]  head_hi [3];
    logic [15:0] wait_left [3];
    logic [3:0]  amp [3];
    logic        hw_env [3];
    logic        active [3];
    logic [3:0]  env_pattern;

    psgd_pkg::res_t burst [3];
    int          burst_n;

    assign pending_count = expected_q.size();

    task automatic add(input psgd_pkg::kind_t k, input logic [3:0] a, input logic [7:0] v,
                       input logic [3:0] e);
        burst[burst_n] = psgd_pkg::mk(k, a, v, e);
        burst_n++;
    endtask

    task automatic abort_voice(input int ch);
        active[ch] = 1'b0;
        phase[ch] = psgd_pkg::PH_HEAD0;
        body_left[ch] = 3'd0;
        add(psgd_pkg::K_ERROR, 4'd0, 8'd0, 4'd0);
    endtask

    task automatic after_cmd(input int ch);
        phase[ch] = (body_left[ch] != 0) ? psgd_pkg::PH_CMD : psgd_pkg::PH_HEAD0;
    endtask

    task automatic decode_byte(input int ch, input logic [7:0] x, input logic muted);
        logic [3:0] nib;
        int         need;
        int         sum;
        nib = x[7:4];
        case (phase[ch])
            psgd_pkg::PH_HEAD0: begin
                if (x == psgd_pkg::END_MARK) begin
                    active[ch] = 1'b0;
                    add(psgd_pkg::K_END, 4'd0, 8'd0, 4'd0);
                end else begin
                    head_hi[ch] = x;
                    phase[ch] = psgd_pkg::PH_HEAD1;
                end
            end
            psgd_pkg::PH_HEAD1: begin
                sum = int'(wait_left[ch]) + 4 * int'({head_hi[ch][4:0], x});
                wait_left[ch] = (sum > 65535) ? 16'hffff : sum[15:0];
                body_left[ch] = head_hi[ch][7:5];
                if (body_left[ch] == 0)
                    phase[ch] = psgd_pkg::PH_HEAD0;
                else
                    phase[ch] = muted ? psgd_pkg::PH_SKIP : psgd_pkg::PH_CMD;
            end
            psgd_pkg::PH_SKIP: begin
                if (body_left[ch] != 0) body_left[ch]--;
                if (body_left[ch] == 0) phase[ch] = psgd_pkg::PH_HEAD0;
            end
            psgd_pkg::PH_CMD: begin
                if (body_left[ch] != 0) body_left[ch]--;
                if (nib == psgd_pkg::OP_TONE_KEY || nib == psgd_pkg::OP_TONE ||
                    nib == psgd_pkg::OP_MIXER) need = 1;
                else if (nib == psgd_pkg::OP_CYCLE || nib == psgd_pkg::OP_PAT_CYCLE) need = 2;
                else need = 0;
                if (need > int'(body_left[ch])) begin
                    abort_voice(ch);
                end else begin
                    cmd_byte[ch] = x;
                    case (nib) inside
                        psgd_pkg::OP_TONE_KEY: begin
                            add(psgd_pkg::K_KEYON, 4'd0, 8'd0, 4'd0);
                            if (hw_env[ch]) begin
                                add(psgd_pkg::K_WRITE, psgd_pkg::REG_ENV_SHAPE,
                                    {4'd0, env_pattern}, 4'd0);
                                add(psgd_pkg::K_WRITE, psgd_pkg::REG_VOL_BASE + 4'(ch),
                                    psgd_pkg::HW_ENV_VOL, 4'd0);
                            end
                            phase[ch] = psgd_pkg::PH_OPND1;
                        end
                        psgd_pkg::OP_TONE, psgd_pkg::OP_MIXER, psgd_pkg::OP_CYCLE:
                            phase[ch] = psgd_pkg::PH_OPND1;
                        psgd_pkg::OP_KEY_OFF: begin
                            add(psgd_pkg::K_KEYOFF, 4'd0, 8'd0, 4'd0);
                            if (hw_env[ch])
                                add(psgd_pkg::K_WRITE, psgd_pkg::REG_VOL_BASE + 4'(ch),
                                    8'd0, 4'd0);
                            after_cmd(ch);
                        end
                        psgd_pkg::OP_NOISE_A, psgd_pkg::OP_NOISE_B: begin
                            add(psgd_pkg::K_WRITE, psgd_pkg::REG_NOISE,
                                {3'd0, x[4:0] & psgd_pkg::NOISE_MASK}, 4'd0);
                            after_cmd(ch);
                        end
                        psgd_pkg::OP_AMP: begin
                            amp[ch] = x[3:0];
                            hw_env[ch] = 1'b0;
                            after_cmd(ch);
                        end
                        psgd_pkg::OP_ENV_SEL: begin
                            hw_env[ch] = 1'b0;
                            add(psgd_pkg::K_ENVSEL, 4'd0, 8'd0, x[3:0]);
                            after_cmd(ch);
                        end
                        psgd_pkg::OP_PATTERN, psgd_pkg::OP_PAT_CYCLE: begin
                            env_pattern = x[3:0];
                            hw_env[ch] = 1'b1;
                            if (nib == psgd_pkg::OP_PAT_CYCLE) phase[ch] = psgd_pkg::PH_OPND1;
                            else after_cmd(ch);
                        end
                        default: abort_voice(ch);
                    endcase
                end
            end
            psgd_pkg::PH_OPND1: begin
                if (body_left[ch] != 0) body_left[ch]--;
                nib = cmd_byte[ch][7:4];
                if (nib == psgd_pkg::OP_TONE_KEY || nib == psgd_pkg::OP_TONE) begin
                    add(psgd_pkg::K_WRITE, 4'(1 + 2 * ch), {4'd0, cmd_byte[ch][3:0]}, 4'd0);
                    add(psgd_pkg::K_WRITE, 4'(2 * ch), x, 4'd0);
                    after_cmd(ch);
                end else if (nib == psgd_pkg::OP_MIXER) begin
                    add(psgd_pkg::K_WRITE, psgd_pkg::REG_MIXER, x, 4'd0);
                    after_cmd(ch);
                end else begin
                    add(psgd_pkg::K_WRITE, psgd_pkg::REG_ENV_COARSE, x, 4'd0);
                    phase[ch] = psgd_pkg::PH_OPND2;
                end
            end
            psgd_pkg::PH_OPND2: begin
                if (body_left[ch] != 0) body_left[ch]--;
                add(psgd_pkg::K_WRITE, psgd_pkg::REG_ENV_FINE, x, 4'd0);
                after_cmd(ch);
            end
            default: phase[ch] = psgd_pkg::PH_HEAD0;
        endcase
    endtask

    task automatic decode_request(input logic [1:0] fn, input logic [15:0] req);
        psgd_pkg::func_t f;
        int         ch;
        logic [7:0] d;
        logic       m;
        int         lvl;
        f = psgd_pkg::func_t'(fn);
        ch = req[1:0];
        d = req[9:2];
        m = req[10];
        burst_n = 0;
        if (ch < 3) begin
            if (f == psgd_pkg::F_START) begin
                active[ch] = 1'b1;
                phase[ch] = psgd_pkg::PH_HEAD0;
                body_left[ch] = 3'd0;
                wait_left[ch] = 16'd0;
            end else if (active[ch]) begin
                if (f == psgd_pkg::F_BYTE) begin
                    decode_byte(ch, d, m);
                end else if (f == psgd_pkg::F_TICK) begin
                    if (16'(d) < wait_left[ch]) begin
                        wait_left[ch] = wait_left[ch] - 16'(d);
                        add(psgd_pkg::K_WAIT, 4'd0, 8'd0, 4'd0);
                    end else begin
                        wait_left[ch] = 16'd0;
                        add(psgd_pkg::K_DUE, 4'd0, 8'd0, 4'd0);
                    end
                end else if (!m && !hw_env[ch]) begin
                    lvl = int'(d[7:4]) + int'(amp[ch]) + int'(master_vol) -
                          psgd_pkg::LEVEL_OFFSET;
                    if (lvl < 0) lvl = 0;
                    add(psgd_pkg::K_WRITE, psgd_pkg::REG_VOL_BASE + 4'(ch), lvl[7:0], 4'd0);
                end
            end
        end
        for (int i = 0; i < burst_n; i++)
            expected_q.push_back('{r: burst[i], last: (i == burst_n - 1)});
    endtask

    task automatic compare_result(input logic [2:0] tu, input logic [15:0] td,
                                  input logic tl);
        decoded_t e;
        psgd_pkg::res_t got;
        got = psgd_pkg::mk(psgd_pkg::kind_t'(tu), td[3:0], td[11:4], td[15:12]);
        result_count++;
        if (expected_q.size() == 0) begin
            $error("unexpected result kind %0d addr %0d value %0d", got.kind,
                   got.reg_addr, got.reg_value);
            fail_count++;
        end else begin
            e = expected_q.pop_front();
            if (got.kind != e.r.kind) begin
                $error("kind: expected %0d, got %0d", e.r.kind, got.kind);
                fail_count++;
            end
            if (got.reg_addr != e.r.reg_addr) begin
                $error("reg_addr: expected %0d, got %0d", e.r.reg_addr, got.reg_addr);
                fail_count++;
            end
            if (got.reg_value != e.r.reg_value) begin
                $error("reg_value: expected %0d, got %0d", e.r.reg_value, got.reg_value);
                fail_count++;
            end
            if (got.env_index != e.r.env_index) begin
                $error("env_index: expected %0d, got %0d", e.r.env_index, got.env_index);
                fail_count++;
            end
            if (tl != e.last) begin
                $error("last: expected %0d, got %0d", e.last, tl);
                fail_count++;
            end
        end
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            master_vol = 4'd15;
            env_pattern = 4'd0;
            for (int i = 0; i < 3; i++) begin
                phase[i] = psgd_pkg::PH_HEAD0;
                body_left[i] = 3'd0;
                cmd_byte[i] = 8'd0;
                head_hi[i] = 8'd0;
                wait_left[i] = 16'd0;
                amp[i] = 4'd0;
                hw_env[i] = 1'b0;
                active[i] = 1'b0;
            end
        end else begin
            if (cfg_valid && cfg_ready) master_vol = cfg_data;
            if (s_tvalid && s_tready) decode_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) compare_result(m_tuser, m_tdata, m_tlast);
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [2:0]  m_tuser;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    int fail_count;
    int pending_count;
    int result_count;
    int sent;
    int burst_left;
    int idle_cycles;
    int stall_mode;

    psg_music_stream_decoder_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    psgd_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver stall pattern: free-running stretches, then random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_mode <= 0;
        end else begin
            stall_mode <= (stall_mode + 1) % 96;
            if (stall_mode < 32) m_tready <= 1'b1;
            else if (stall_mode < 64) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog on cycles with no accepted request, result or volume setting
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic send(input psgd_pkg::func_t f, input int ch, input logic [7:0] d,
                        input logic m);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {5'd0, m, d, 2'(ch)};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic set_volume(input logic [3:0] v);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one chunk of random content, mostly well formed
    task automatic send_chunk(input int ch);
        int         len;
        int         left;
        logic [3:0] nib;
        int         need;
        logic       muted;
        logic       broken;
        logic       bad;
        len = $urandom_range(0, 7);
        muted = ($urandom_range(0, 5) == 0);
        broken = 1'b0;
        send(psgd_pkg::F_BYTE, ch, {3'(len), 5'($urandom_range(0, 31))}, $urandom_range(0, 1));
        send(psgd_pkg::F_BYTE, ch, 8'($urandom), muted);
        left = len;
        while (left > 0 && !broken) begin
            nib = 4'($urandom);
            need = (nib == psgd_pkg::OP_TONE_KEY || nib == psgd_pkg::OP_TONE ||
                    nib == psgd_pkg::OP_MIXER) ? 1 :
                   (nib == psgd_pkg::OP_CYCLE || nib == psgd_pkg::OP_PAT_CYCLE) ? 2 : 0;
            if (!muted && need > left - 1 && $urandom_range(0, 7) != 0) begin
                nib = psgd_pkg::OP_AMP;
                need = 0;
            end
            bad = !(nib inside {psgd_pkg::OP_TONE_KEY, psgd_pkg::OP_KEY_OFF,
                                psgd_pkg::OP_NOISE_A, psgd_pkg::OP_NOISE_B,
                                psgd_pkg::OP_CYCLE, psgd_pkg::OP_MIXER, psgd_pkg::OP_AMP,
                                psgd_pkg::OP_PATTERN, psgd_pkg::OP_ENV_SEL,
                                psgd_pkg::OP_PAT_CYCLE, psgd_pkg::OP_TONE});
            if (!muted && bad && $urandom_range(0, 3) != 0) begin
                nib = psgd_pkg::OP_KEY_OFF;
                bad = 1'b0;
            end
            send(psgd_pkg::F_BYTE, ch, {nib, 4'($urandom)}, $urandom_range(0, 1));
            left--;
            if (!muted && (need > left || bad))
                broken = 1'b1;
            for (int i = 0; i < need && left > 0 && !broken; i++) begin
                send(psgd_pkg::F_BYTE, ch, 8'($urandom), $urandom_range(0, 1));
                left--;
            end
        end
        if (broken) send(psgd_pkg::F_START, ch, 8'($urandom), 1'b0);
    endtask

    initial begin
        int ch;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        sent = 0;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: inactive voice, bad channel, start, levels, end marks
        send(psgd_pkg::F_BYTE, 0, 8'h12, 1'b0);
        send(psgd_pkg::F_TICK, 1, 8'd5, 1'b0);
        send(psgd_pkg::F_START, 3, 8'hff, 1'b1);
        send(psgd_pkg::F_LEVEL, 3, 8'hff, 1'b0);
        for (int v = 0; v < 3; v++) send(psgd_pkg::F_START, v, 8'd0, 1'b0);
        send(psgd_pkg::F_LEVEL, 0, 8'hf0, 1'b0);
        send(psgd_pkg::F_LEVEL, 1, 8'h00, 1'b0);
        send(psgd_pkg::F_LEVEL, 2, 8'hf0, 1'b1);
        send(psgd_pkg::F_BYTE, 0, 8'hff, 1'b1);
        send(psgd_pkg::F_TICK, 1, 8'd0, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'hff, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'hff, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h8f, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h95, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h0a, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h5c, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h1f, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h3f, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'hc7, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'hff, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'hff, 1'b0);
        send(psgd_pkg::F_TICK, 1, 8'hff, 1'b0);
        send(psgd_pkg::F_BYTE, 1, 8'h5d, 1'b0);

        set_volume(4'd0);
        for (int v = 0; v < 3; v++) send(psgd_pkg::F_START, v, 8'd0, 1'b0);
        while (sent < 360) begin
            if (sent > 240 && sent < 260) set_volume(4'd15);
            else if (sent > 120 && sent < 140) set_volume(4'($urandom));
            ch = $urandom_range(0, 2);
            case ($urandom_range(0, 9))
                0: send(psgd_pkg::F_TICK, ch, 8'($urandom), $urandom_range(0, 1));
                1: send(psgd_pkg::F_LEVEL, ch, 8'($urandom), ($urandom_range(0, 3) == 0));
                2: send(psgd_pkg::func_t'($urandom_range(0, 3)), 3, 8'($urandom),
                        $urandom_range(0, 1));
                3: send(psgd_pkg::F_START, ch, 8'($urandom), $urandom_range(0, 1));
                default: send_chunk(ch);
            endcase
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered %0d requests, %0d results, volumes 0, 15 and random",
                 sent, result_count);
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
